### hw/rtl/tlpw_pkg.sv
// shared types and constants of the two-level page-walk mmu
// payload structs, register indexes, status and size codes, store geometry
// no dependencies
package tlpw_pkg;

    localparam int unsigned PHYS_BYTES = 65536;
    localparam int unsigned PHYS_AW    = $clog2(PHYS_BYTES);

    localparam logic       REG_PAGING_ENABLE = 1'b0;
    localparam logic       REG_DIR_FRAME     = 1'b1;

    localparam logic       OP_READ  = 1'b0;
    localparam logic       OP_WRITE = 1'b1;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_DIR_ABSENT = 2'd1;
    localparam logic [1:0] ST_TBL_ABSENT = 2'd2;
    localparam logic [1:0] ST_BEYOND     = 2'd3;

    typedef struct packed {
        logic        op;
        logic [31:0] vaddr;
        logic [31:0] wdata;
        logic [1:0]  size_code;
    } req_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic [1:0]  status;
    } rsp_t;

    // shared address unit: base + offset, bound check on the last byte touched
    typedef struct packed {
        logic [31:0] base;
        logic [31:0] offset;
        logic [1:0]  last;
    } agu_req_t;

    typedef struct packed {
        logic [31:0] sum;
        logic        beyond;
    } agu_rsp_t;

endpackage

### hw/rtl/two_level_page_walk_mmu_core.sv
// Two-level page-walk mmu with a built-in 64 KiB byte store. One beat at a time:
// req_stall is high from acceptance until the result is formed in the output
// register. Latency is set by the single byte-wide store port and the shared
// address adder. With paging off each byte is bound-checked, then the data pass
// runs. With paging on, the first byte and each byte that starts a new page cost
// a page walk (two 4-byte entry reads plus checks), each further byte in the same
// page reuses its frame, and the data pass follows; then the result is posted.
// A result still held in the output register keeps the block in its posting
// state. The store has no reset and no clearing pass; reading bytes never
// written returns undefined data.
module two_level_page_walk_mmu_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [19:0]      cfg_wdata,
    input  logic             req_valid,
    output logic             req_stall,
    input  tlpw_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output tlpw_pkg::rsp_t   rsp
);

    localparam int unsigned AW = tlpw_pkg::PHYS_AW;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_XLATE    = 4'd1;
    localparam logic [3:0] S_PDE_CHK  = 4'd2;
    localparam logic [3:0] S_PDE_RD   = 4'd3;
    localparam logic [3:0] S_PTE_CHK  = 4'd4;
    localparam logic [3:0] S_PTE_RD   = 4'd5;
    localparam logic [3:0] S_PTE_EVAL = 4'd6;
    localparam logic [3:0] S_PHYS_CHK = 4'd7;
    localparam logic [3:0] S_ACCESS   = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic        paging_reg;
    logic [19:0] dir_frame_reg;

    logic        op_reg;
    logic [31:0] vaddr_reg;
    logic [31:0] wdata_reg;
    logic [1:0]  last_reg;
    logic [1:0]  last_next;

    logic [1:0]  idx_reg, idx_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] cur_va_reg, cur_va_next;
    logic [AW-1:0] ent_addr_reg, ent_addr_next;
    logic [31:0] word_reg, word_next;
    logic [19:0] frame_reg, frame_next;
    logic [1:0]  status_reg, status_next;
    logic [1:0]  lane;

    logic [AW-1:0] pa_reg [4];
    logic          pa_we;

    tlpw_pkg::rsp_t rsp_reg;
    logic           rsp_valid_reg;
    logic           rsp_load;

    tlpw_pkg::agu_req_t agu_req;
    tlpw_pkg::agu_rsp_t agu_rsp;

    logic          store_we;
    logic [AW-1:0] store_addr;
    logic [7:0]    store_wdata;
    logic [7:0]    store_rdata;

    logic          req_take;
    logic          issue;

    tlpw_agu u_agu (
        .req (agu_req),
        .rsp (agu_rsp)
    );

    tlpw_store u_store (
        .clk   (clk),
        .we    (store_we),
        .addr  (store_addr),
        .wdata (store_wdata),
        .rdata (store_rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // byte lane of the read data returned this cycle
    assign lane = cnt_reg[1:0] - 2'd1;

    always_comb
    begin
        case (req.size_code)
            tlpw_pkg::SIZE_BYTE: last_next = 2'd0;
            tlpw_pkg::SIZE_HALF: last_next = 2'd1;
            default:             last_next = 2'd3;
        endcase
    end

    // store port: entry reads in the walk, data bytes in the access pass
    always_comb
    begin
        issue       = 1'b0;
        store_we    = 1'b0;
        store_addr  = ent_addr_reg;
        store_wdata = wdata_reg[8*cnt_reg[1:0] +: 8];
        case (state_reg)
            S_PDE_RD, S_PTE_RD:
            begin
                store_addr = {ent_addr_reg[AW-1:2], cnt_reg[1:0]};
            end
            S_ACCESS:
            begin
                issue      = (cnt_reg <= {1'b0, last_reg});
                store_addr = pa_reg[cnt_reg[1:0]];
                store_we   = issue && (op_reg == tlpw_pkg::OP_WRITE);
            end
            default:
            begin
                store_addr = ent_addr_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        cur_va_next   = cur_va_reg;
        ent_addr_next = ent_addr_reg;
        word_next     = word_reg;
        frame_next    = frame_reg;
        status_next   = status_reg;
        pa_we         = 1'b0;
        rsp_load      = 1'b0;
        agu_req       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    idx_next    = 2'd0;
                    status_next = tlpw_pkg::ST_OK;
                    state_next  = S_XLATE;
                end
            end
            S_XLATE:
            begin
                agu_req.base   = vaddr_reg;
                agu_req.offset = {30'b0, idx_reg};
                cur_va_next    = agu_rsp.sum;
                if (!paging_reg)
                begin
                    if (agu_rsp.beyond)
                    begin
                        status_next = tlpw_pkg::ST_BEYOND;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        pa_we = 1'b1;
                        if (idx_reg == last_reg)
                        begin
                            cnt_next   = 3'd0;
                            word_next  = '0;
                            state_next = S_ACCESS;
                        end
                        else
                        begin
                            idx_next = idx_reg + 2'd1;
                        end
                    end
                end
                else if (idx_reg == 2'd0 || agu_rsp.sum[11:0] == 12'h000)
                begin
                    state_next = S_PDE_CHK;
                end
                else
                begin
                    // same page as the previous byte: reuse its frame
                    state_next = S_PHYS_CHK;
                end
            end
            S_PDE_CHK:
            begin
                agu_req.base   = {dir_frame_reg, 12'h000};
                agu_req.offset = {20'b0, cur_va_reg[31:22], 2'b00};
                agu_req.last   = 2'd3;
                ent_addr_next  = agu_rsp.sum[AW-1:0];
                cnt_next       = 3'd0;
                if (agu_rsp.beyond)
                begin
                    status_next = tlpw_pkg::ST_BEYOND;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_PDE_RD;
                end
            end
            S_PDE_RD, S_PTE_RD:
            begin
                // read data lags the address: the store returns it in the next cycle
                if (cnt_reg != 3'd0)
                begin
                    word_next[{lane, 3'b000} +: 8] = store_rdata;
                end
                if (cnt_reg == 3'd4)
                begin
                    cnt_next   = 3'd0;
                    state_next = (state_reg == S_PDE_RD) ? S_PTE_CHK : S_PTE_EVAL;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            S_PTE_CHK:
            begin
                agu_req.base   = {word_reg[31:12], 12'h000};
                agu_req.offset = {20'b0, cur_va_reg[21:12], 2'b00};
                agu_req.last   = 2'd3;
                ent_addr_next  = agu_rsp.sum[AW-1:0];
                cnt_next       = 3'd0;
                if (!word_reg[0])
                begin
                    status_next = tlpw_pkg::ST_DIR_ABSENT;
                    state_next  = S_DONE;
                end
                else if (agu_rsp.beyond)
                begin
                    status_next = tlpw_pkg::ST_BEYOND;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_PTE_RD;
                end
            end
            S_PTE_EVAL:
            begin
                frame_next = word_reg[31:12];
                if (!word_reg[0])
                begin
                    status_next = tlpw_pkg::ST_TBL_ABSENT;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_PHYS_CHK;
                end
            end
            S_PHYS_CHK:
            begin
                agu_req.base   = {frame_reg, 12'h000};
                agu_req.offset = {20'b0, cur_va_reg[11:0]};
                if (agu_rsp.beyond)
                begin
                    status_next = tlpw_pkg::ST_BEYOND;
                    state_next  = S_DONE;
                end
                else
                begin
                    pa_we = 1'b1;
                    if (idx_reg == last_reg)
                    begin
                        cnt_next   = 3'd0;
                        word_next  = '0;
                        state_next = S_ACCESS;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = S_XLATE;
                    end
                end
            end
            S_ACCESS:
            begin
                if (cnt_reg != 3'd0)
                begin
                    word_next[{lane, 3'b000} +: 8] = store_rdata;
                end
                if (issue)
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            paging_reg    <= 1'b0;
            dir_frame_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == tlpw_pkg::REG_PAGING_ENABLE)
                begin
                    paging_reg <= cfg_wdata[0];
                end
                else
                begin
                    dir_frame_reg <= cfg_wdata;
                end
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            op_reg    <= req.op;
            vaddr_reg <= req.vaddr;
            wdata_reg <= req.wdata;
            last_reg  <= last_next;
        end
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        cur_va_reg   <= cur_va_next;
        ent_addr_reg <= ent_addr_next;
        word_reg     <= word_next;
        frame_reg    <= frame_next;
        status_reg   <= status_next;
        if (pa_we)
        begin
            pa_reg[idx_reg] <= agu_rsp.sum[AW-1:0];
        end
        if (rsp_load)
        begin
            rsp_reg.status <= status_reg;
            rsp_reg.rdata  <= (status_reg == tlpw_pkg::ST_OK && op_reg == tlpw_pkg::OP_READ)
                              ? word_reg : 32'h0;
        end
    end

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> req_stall)
        else $error("block did not go busy after taking a beat");

    a_write_only_in_access: assert property (@(posedge clk) disable iff (!rst_n)
        store_we |-> (state_reg == S_ACCESS && op_reg == tlpw_pkg::OP_WRITE
                      && status_reg == tlpw_pkg::ST_OK))
        else $error("store written outside the data pass of a write");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |-> state_reg == S_DONE)
        else $error("result posted outside the done state");

    a_fault_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != tlpw_pkg::ST_OK) |-> rsp.rdata == 32'h0)
        else $error("faulting result carries nonzero read data");

endmodule

### hw/rtl/tlpw_store.sv
// byte-wide physical store, one port, registered read
// depends on tlpw_pkg for the store geometry
module tlpw_store (
    input  logic                         clk,
    input  logic                         we,
    input  logic [tlpw_pkg::PHYS_AW-1:0] addr,
    input  logic [7:0]                   wdata,
    output logic [7:0]                   rdata
);

    logic [7:0] mem [tlpw_pkg::PHYS_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/tlpw_agu.sv
// shared address adder with bound compare against the store size
// depends on tlpw_pkg for the agu structs and store size
module tlpw_agu (
    input  tlpw_pkg::agu_req_t req,
    output tlpw_pkg::agu_rsp_t rsp
);

    localparam logic [32:0] LAST_BYTE = 33'(tlpw_pkg::PHYS_BYTES - 1);

    logic [32:0] sum;
    logic [32:0] lim;

    always_comb
    begin
        sum        = {1'b0, req.base} + {1'b0, req.offset};
        // sum + last beyond the store <=> sum > last byte - last
        lim        = LAST_BYTE - {31'b0, req.last};
        rsp.sum    = sum[31:0];
        rsp.beyond = (sum > lim);
    end

endmodule

### verif/tb.sv
// testbench for two_level_page_walk_mmu_core: directed and random virtual reads and
// writes, checked against a byte-level predictor of the store and the two-level walk
// depends on tlpw_pkg (payload structs, register, op, size and status codes)
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  SIZE_WORD     = 2'd2;
    localparam logic [1:0]  SIZE_SPARE    = 2'd3;
    localparam logic [19:0] DIR_HOME      = 20'd1;
    localparam logic [19:0] DIR_TOP       = 20'd15;
    localparam logic [19:0] DIR_NOWHERE   = 20'hFFFFF;
    localparam logic [19:0] TBL_FRAME_A   = 20'd2;
    localparam logic [19:0] TBL_FRAME_B   = 20'd3;
    localparam int          DATA_FRAME_LO = 4;
    localparam int          DATA_FRAMES   = 11;
    localparam int          SLOTS         = 8;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          TAIL_CYCLES   = 60;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          CYCLE_LIMIT   = 1000000;

    typedef enum {ENT_ABSENT, ENT_BEYOND, ENT_MAP_A, ENT_MAP_B} entry_kind_t;
    typedef enum {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_TOGGLE} flow_mode_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           cfg_we    = 1'b0;
    logic           cfg_index = tlpw_pkg::REG_PAGING_ENABLE;
    logic [19:0]    cfg_wdata = '0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    tlpw_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    tlpw_pkg::rsp_t rsp;

    // predictor state: register copies and the store image with written marks
    logic        pg_on  = 1'b0;
    logic [19:0] dir_fr = '0;
    bit [7:0]    phys_img   [tlpw_pkg::PHYS_BYTES];
    bit          phys_known [tlpw_pkg::PHYS_BYTES];

    tlpw_pkg::rsp_t result_q[$];
    logic [31:0] written_va[$];
    int          mismatches  = 0;
    int          burst_left  = 0;
    int          hold_asked  = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;
    int          mode_left   = 0;
    flow_mode_t  flow_mode   = FLOW_FREE;
    int          cycle_count = 0;

    two_level_page_walk_mmu_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic flag_mismatch(string what);
        $display("error at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // little-endian entry fetch; false when the last byte lies beyond the store
    function automatic bit fetch_word(input longint unsigned a, output logic [31:0] w,
                                      inout bit blind);
        w = '0;
        if (a + 3 >= tlpw_pkg::PHYS_BYTES)
            return 1'b0;
        for (int i = 3; i >= 0; i--)
        begin
            if (!phys_known[a + i])
                blind = 1'b1;
            w = {w[23:0], phys_img[a + i]};
        end
        return 1'b1;
    endfunction

    // works out one access; blind is set when it would read a never-written byte
    function automatic void model_access(input tlpw_pkg::req_t r, input bit commit,
                                         output tlpw_pkg::rsp_t res, output bit blind);
        longint unsigned pa [4];
        longint unsigned phys;
        logic [31:0]     va, pde, pte, rd;
        logic [1:0]      st;
        int              len, n_ok;
        len   = (r.size_code == tlpw_pkg::SIZE_BYTE) ? 1
              : (r.size_code == tlpw_pkg::SIZE_HALF) ? 2 : 4;
        blind = 1'b0;
        st    = tlpw_pkg::ST_OK;
        rd    = '0;
        n_ok  = 0;
        pte   = '0;
        for (int i = 0; i < len && st == tlpw_pkg::ST_OK; i++)
        begin
            va = r.vaddr + 32'(i);
            if (!pg_on)
                phys = 64'(r.vaddr) + 64'(i);
            else
            begin
                if (!fetch_word({32'd0, dir_fr, 12'd0} + 64'(va[31:22]) * 4, pde, blind))
                    st = tlpw_pkg::ST_BEYOND;
                else if (!pde[0])
                    st = tlpw_pkg::ST_DIR_ABSENT;
                else if (!fetch_word(64'({pde[31:12], 12'd0}) + 64'(va[21:12]) * 4, pte,
                                     blind))
                    st = tlpw_pkg::ST_BEYOND;
                else if (!pte[0])
                    st = tlpw_pkg::ST_TBL_ABSENT;
                phys = 64'({pte[31:12], va[11:0]});
            end
            if (st == tlpw_pkg::ST_OK && phys >= tlpw_pkg::PHYS_BYTES)
                st = tlpw_pkg::ST_BEYOND;
            if (st == tlpw_pkg::ST_OK)
            begin
                pa[n_ok] = phys;
                n_ok++;
            end
        end
        // a read is kept away from unwritten data even when it faults later
        if (r.op == tlpw_pkg::OP_READ)
            for (int i = 0; i < n_ok; i++)
                if (!phys_known[pa[i]])
                    blind = 1'b1;
        if (st == tlpw_pkg::ST_OK)
            for (int i = 0; i < len; i++)
            begin
                if (r.op == tlpw_pkg::OP_WRITE && commit)
                begin
                    phys_img[pa[i]]   = r.wdata[8*i +: 8];
                    phys_known[pa[i]] = 1'b1;
                end
                else if (r.op == tlpw_pkg::OP_READ)
                    rd |= 32'(phys_img[pa[i]]) << (8 * i);
            end
        res.rdata  = (r.op == tlpw_pkg::OP_READ && st == tlpw_pkg::ST_OK) ? rd : '0;
        res.status = st;
    endfunction

    function automatic logic [9:0] slot_index(int k);
        case (k % SLOTS)
            0:       return 10'd0;
            1:       return 10'd1;
            2:       return 10'd2;
            3:       return 10'd3;
            4:       return 10'd511;
            5:       return 10'd512;
            6:       return 10'd1022;
            default: return 10'd1023;
        endcase
    endfunction

    function automatic entry_kind_t pattern_kind(bit is_dir, int k);
        if (is_dir)
            case (k % SLOTS)
                1, 6:    return ENT_ABSENT;
                2:       return ENT_BEYOND;
                3, 4:    return ENT_MAP_B;
                default: return ENT_MAP_A;
            endcase
        case (k % SLOTS)
            5:       return ENT_ABSENT;
            6:       return ENT_BEYOND;
            default: return ENT_MAP_A;
        endcase
    endfunction

    // ignored flag bits and the frame of an absent entry carry random content
    function automatic logic [31:0] make_entry(entry_kind_t kind, logic [19:0] frame);
        logic [11:0] flags;
        flags = 12'($urandom) & 12'hFFE;
        case (kind)
            ENT_ABSENT: return {20'($urandom), flags};
            ENT_BEYOND: return {20'($urandom_range(16, 'hFFFFF)), flags | 12'h1};
            default:    return {frame, flags | 12'h1};
        endcase
    endfunction

    task automatic send_beat(tlpw_pkg::req_t r);
        tlpw_pkg::rsp_t due;
        bit             blind;
        int             gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        model_access(r, 1'b1, due, blind);
        result_q.push_back(due);
        if (r.op == tlpw_pkg::OP_WRITE && due.status == tlpw_pkg::ST_OK)
        begin
            written_va.push_back(r.vaddr);
            if (written_va.size() > 48)
                void'(written_va.pop_front());
        end
        @(negedge clk);
    endtask

    task automatic issue(logic op, logic [31:0] va, logic [31:0] wd, logic [1:0] sz);
        tlpw_pkg::req_t r;
        r.op        = op;
        r.vaddr     = va;
        r.wdata     = wd;
        r.size_code = sz;
        send_beat(r);
    endtask

    // block goes idle once every outstanding result has been taken
    task automatic settle();
        req_valid <= 1'b0;
        while (result_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_reg(logic idx, logic [19:0] val);
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == tlpw_pkg::REG_PAGING_ENABLE)
            pg_on = val[0];
        else
            dir_fr = val;
        written_va.delete();
    endtask

    // directory entries are written through the block with paging off
    task automatic enter_paging(logic [19:0] frame, int rot);
        entry_kind_t kind;
        settle();
        set_reg(tlpw_pkg::REG_PAGING_ENABLE, 20'd0);
        if (frame < 16)
            for (int k = 0; k < SLOTS; k++)
            begin
                kind = pattern_kind(1'b1, k + rot);
                issue(tlpw_pkg::OP_WRITE, {frame, 12'h0} + 32'(slot_index(k)) * 4,
                      make_entry(kind, (kind == ENT_MAP_B) ? TBL_FRAME_B : TBL_FRAME_A),
                      SIZE_WORD);
            end
        settle();
        set_reg(tlpw_pkg::REG_DIR_FRAME, frame);
        set_reg(tlpw_pkg::REG_PAGING_ENABLE, 20'd1);
    endtask

    // mostly mapped slots and page-crossing offsets, reads aimed at written bytes
    task automatic run_random(int count);
        tlpw_pkg::req_t r;
        tlpw_pkg::rsp_t probe;
        bit             blind;
        int             pick;
        logic [11:0]    off;
        repeat (count)
        begin
            do
            begin
                r.op        = 1'($urandom_range(0, 1));
                r.wdata     = $urandom;
                r.size_code = 2'($urandom_range(0, 3));
                pick        = $urandom_range(0, 99);
                off         = (pick < 60) ? 12'($urandom) : 12'($urandom_range('hFF9, 'hFFF));
                if (r.op == tlpw_pkg::OP_READ && written_va.size() > 0 && pick < 75)
                    r.vaddr = written_va[$urandom_range(0, written_va.size() - 1)];
                else if (pick >= 95)
                    r.vaddr = $urandom;
                else if (!pg_on)
                    r.vaddr = (pick < 85)
                              ? $urandom_range(0, tlpw_pkg::PHYS_BYTES - 1)
                              : $urandom_range(tlpw_pkg::PHYS_BYTES - 8,
                                               tlpw_pkg::PHYS_BYTES + 3);
                else
                    r.vaddr = {slot_index($urandom_range(0, SLOTS - 1)),
                               slot_index($urandom_range(0, SLOTS - 1)), off};
                model_access(r, 1'b0, probe, blind);
            end
            while (blind);
            send_beat(r);
        end
    endtask

    task automatic test_physical_directed();
        issue(tlpw_pkg::OP_WRITE, 32'h0000_0000, 32'hA5C3_0F81, SIZE_WORD);
        issue(tlpw_pkg::OP_READ,  32'h0000_0000, 32'h0,         SIZE_WORD);
        issue(tlpw_pkg::OP_READ,  32'h0000_0003, 32'h0,         tlpw_pkg::SIZE_BYTE);
        issue(tlpw_pkg::OP_READ,  32'h0000_0001, 32'h0,         tlpw_pkg::SIZE_HALF);
        // last word of the store, then accesses at its end and running past it
        issue(tlpw_pkg::OP_WRITE, 32'h0000_FFFC, 32'hFFFF_FFFF, SIZE_WORD);
        issue(tlpw_pkg::OP_READ,  32'h0000_FFFF, 32'h0,         tlpw_pkg::SIZE_BYTE);
        issue(tlpw_pkg::OP_READ,  32'h0000_FFFE, 32'h0,         tlpw_pkg::SIZE_HALF);
        issue(tlpw_pkg::OP_WRITE, 32'h0000_FFFF, 32'h1234_5678, tlpw_pkg::SIZE_HALF);
        issue(tlpw_pkg::OP_READ,  32'h0000_FFFD, 32'h0,         SIZE_WORD);
        issue(tlpw_pkg::OP_WRITE, 32'h0000_0100, 32'h5A5A_1234, SIZE_SPARE);
        issue(tlpw_pkg::OP_READ,  32'h0000_0100, 32'h0,         SIZE_SPARE);
        issue(tlpw_pkg::OP_READ,  32'hFFFF_FFFF, 32'h0,         tlpw_pkg::SIZE_BYTE);
        issue(tlpw_pkg::OP_WRITE, 32'hFFFF_FFFE, 32'hFFFF_FFFF, tlpw_pkg::SIZE_HALF);
        issue(tlpw_pkg::OP_READ,  32'h0001_0000, 32'h0,         tlpw_pkg::SIZE_BYTE);
        issue(tlpw_pkg::OP_WRITE, 32'h0000_0200, 32'h0,         SIZE_WORD);
        issue(tlpw_pkg::OP_READ,  32'h0000_0200, 32'h0,         SIZE_WORD);
    endtask

    task automatic test_physical_random();
        run_random(250);
    endtask

    task automatic test_paging_directed();
        entry_kind_t kind;
        for (int t = 0; t < 2; t++)
            for (int j = 0; j < SLOTS; j++)
            begin
                kind = pattern_kind(1'b0, j + t);
                issue(tlpw_pkg::OP_WRITE, {(t == 0) ? TBL_FRAME_A : TBL_FRAME_B, 12'h0}
                                          + 32'(slot_index(j)) * 4,
                      make_entry(kind, 20'(DATA_FRAME_LO + (j * 3 + t * 5) % DATA_FRAMES)),
                      SIZE_WORD);
            end
        enter_paging(DIR_HOME, 0);
        issue(tlpw_pkg::OP_WRITE, {10'd0, 10'd0, 12'h010}, $urandom, SIZE_WORD);
        issue(tlpw_pkg::OP_READ,  {10'd0, 10'd0, 12'h010}, 32'h0,    SIZE_WORD);
        // page crossings, one of them wrapping the virtual space
        issue(tlpw_pkg::OP_WRITE, {10'd0, 10'd0, 12'hFFF}, $urandom, tlpw_pkg::SIZE_HALF);
        issue(tlpw_pkg::OP_READ,  {10'd0, 10'd0, 12'hFFF}, 32'h0,    tlpw_pkg::SIZE_HALF);
        issue(tlpw_pkg::OP_WRITE, {10'd1023, 10'd1023, 12'hFFE}, $urandom, SIZE_WORD);
        issue(tlpw_pkg::OP_READ,  {10'd1023, 10'd1023, 12'hFFE}, 32'h0,    SIZE_WORD);
        // each fault kind in turn
        issue(tlpw_pkg::OP_READ,  {10'd1, 10'd0, 12'h000},    32'h0, tlpw_pkg::SIZE_BYTE);
        issue(tlpw_pkg::OP_WRITE, {10'd1022, 10'd3, 12'h000}, $urandom, tlpw_pkg::SIZE_BYTE);
        issue(tlpw_pkg::OP_WRITE, {10'd2, 10'd0, 12'h000},    $urandom, SIZE_WORD);
        issue(tlpw_pkg::OP_READ,  {10'd0, 10'd512, 12'h005},  32'h0, tlpw_pkg::SIZE_BYTE);
        issue(tlpw_pkg::OP_WRITE, {10'd0, 10'd1022, 12'h007}, $urandom, tlpw_pkg::SIZE_BYTE);
        // second page absent: the first two bytes must stay unwritten
        issue(tlpw_pkg::OP_WRITE, {10'd0, 10'd511, 12'hFFE},  $urandom, SIZE_WORD);
        issue(tlpw_pkg::OP_READ,  {10'd0, 10'd0, 12'h010},    32'h0,    SIZE_WORD);
        issue(tlpw_pkg::OP_WRITE, {10'd3, 10'd1, 12'h100},    $urandom, SIZE_SPARE);
        issue(tlpw_pkg::OP_READ,  {10'd3, 10'd1, 12'h100},    32'h0,    SIZE_SPARE);
        issue(tlpw_pkg::OP_WRITE, {10'd1023, 10'd1023, 12'hFFF}, 32'h0, tlpw_pkg::SIZE_BYTE);
        issue(tlpw_pkg::OP_READ,  {10'd1023, 10'd1023, 12'hFFF}, 32'h0, tlpw_pkg::SIZE_BYTE);
    endtask

    task automatic test_paging_random();
        run_random(450);
    endtask

    // receiver holds off while beats keep coming, so the input backs up
    task automatic test_backpressure();
        hold_asked++;
        run_random(25);
    endtask

    task automatic test_directory_frames();
        enter_paging(DIR_TOP, 3);
        run_random(150);
        enter_paging(20'd0, 5);
        run_random(120);
        enter_paging(DIR_NOWHERE, 0);
        run_random(12);
    endtask

    task automatic test_physical_revisit();
        settle();
        set_reg(tlpw_pkg::REG_PAGING_ENABLE, 20'd0);
        run_random(30);
    endtask

    // receiver stall pattern, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_seen != hold_asked)
        begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                flow_mode = flow_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (flow_mode)
                FLOW_FREE:  rsp_stall <= 1'b0;
                FLOW_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 30);
                FLOW_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 75);
                default:    rsp_stall <= ~rsp_stall;
            endcase
        end
    end

    always @(posedge clk)
    begin : check_result
        tlpw_pkg::rsp_t due;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (result_q.size() == 0)
                flag_mismatch($sformatf("result with none pending: rdata %h status %0d",
                                        rsp.rdata, rsp.status));
            else
            begin
                due = result_q.pop_front();
                if (rsp.rdata !== due.rdata)
                    flag_mismatch($sformatf("rdata %h, predicted %h", rsp.rdata, due.rdata));
                if (rsp.status !== due.status)
                    flag_mismatch($sformatf("status %0d, predicted %0d",
                                            rsp.status, due.status));
            end
        end
    end

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_physical_directed();
        test_physical_random();
        test_paging_directed();
        test_paging_random();
        test_backpressure();
        test_directory_frames();
        test_physical_revisit();
        settle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (result_q.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", result_q.size()));
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
